[sv/spa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants of the servo PWM generator
// Register map, reset values, field widths and the pipeline control bundle.
// ----------------------------------------------------------------------------
package spa_pkg;

	localparam int ADC_BITS_DEF = 12;

	localparam int SAMPLE_W = 12;
	localparam int HELD_W   = 12;
	localparam int WIDTH_W  = 16;
	localparam int PERIOD_W = 16;
	localparam int PULSE_W  = 15;
	localparam int CUT_W    = 12;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TICKS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_SPAN      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_CUT         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_CUT        = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_LOW        = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_HIGH       = 3'd7;

	// Item kinds.
	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// Register reset values.
	localparam logic [PERIOD_W-1:0] PERIOD_TICKS_RST    = 16'd20000;
	localparam logic [PULSE_W-1:0]  MIN_PULSE_RST       = 15'd500;
	localparam logic [PULSE_W-1:0]  PULSE_SPAN_RST      = 15'd2000;
	localparam logic [CUT_W-1:0]    HYSTERESIS_STEP_RST = 12'd50;
	localparam logic [CUT_W-1:0]    LOW_CUT_RST         = 12'd300;
	localparam logic [CUT_W-1:0]    HIGH_CUT_RST        = 12'd3900;
	localparam logic [CUT_W-1:0]    DEAD_LOW_RST        = 12'd2100;
	localparam logic [CUT_W-1:0]    DEAD_HIGH_RST       = 12'd2200;

	// State reset values.
	localparam logic [HELD_W-1:0]  CENTRE_LEVEL = 12'd2045;
	localparam logic [WIDTH_W-1:0] WIDTH_RST    = 16'd1500;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_ticks;
		logic [PULSE_W-1:0]  min_pulse;
		logic [PULSE_W-1:0]  pulse_span;
		logic [CUT_W-1:0]    hysteresis_step;
		logic [CUT_W-1:0]    low_cut;
		logic [CUT_W-1:0]    high_cut;
		logic [CUT_W-1:0]    dead_low;
		logic [CUT_W-1:0]    dead_high;
	} cfg_t;

	// Load enables of the pipeline: take fills stage 1, advN moves stage N on.
	typedef struct packed {
		logic take;
		logic adv1;
		logic adv2;
		logic adv3;
	} pipe_ctl_t;

endpackage

[sv/spa_item_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_item_if: input channel of the servo PWM generator
// Carries one ADC sample or one timer tick per transfer.
// ----------------------------------------------------------------------------
interface spa_item_if
	import spa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                action;
	logic [SAMPLE_W-1:0] adc_sample;

	modport source(output valid, action, adc_sample, input ready);
	modport sink(input valid, action, adc_sample, output ready);
endinterface

[sv/spa_result_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_result_if: result channel of the servo PWM generator
// Carries the pin level, pending pulse width and held level per transfer.
// ----------------------------------------------------------------------------
interface spa_result_if
	import spa_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               servo_pin;
	logic [WIDTH_W-1:0] pulse_width;
	logic [HELD_W-1:0]  held_level;

	modport source(output valid, servo_pin, pulse_width, held_level, input ready);
	modport sink(input valid, servo_pin, pulse_width, held_level, output ready);
endinterface

[sv/servo_pwm_from_adc.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_pwm_from_adc: servo PWM generator driven by a joystick ADC
// Smooths ADC samples into a held level, maps it to a pulse width and drives
// the servo pin from a tick-driven period counter.
// ----------------------------------------------------------------------------
// Usage: each transfer on the item channel is either an ADC sample
// (action = 0) or one timer tick (action = 1). Every item yields exactly one
// transfer on the result channel, in order: the pin level after the item,
// the pending pulse width for the next period and the held level.
// The block is a four-register pipeline (input, mapped level, product,
// result) and takes one item per cycle while the result channel does not
// stall; the filter and hysteresis state closes its loop in the first stage
// and the period counter in the third.
// When the result receiver stalls, items keep entering until all four
// registers hold an item; ready then drops until a result transfer frees
// a slot. Configuration registers are written through the plain write port;
// the user must write them only while no item is in flight (not enforced).
// Reset clears the pipeline and sets the registers and state to their
// defaults: pin low, counter zero, pulse widths 1500, levels at centre.
// ----------------------------------------------------------------------------
module servo_pwm_from_adc
	import spa_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	spa_item_if.sink              item,
	spa_result_if.source          result
);

	localparam int LVL_W = (ADC_BITS > HELD_W) ? ADC_BITS : HELD_W;

	cfg_t               cfg;
	pipe_ctl_t          ctl;

	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               out_valid_q;

	logic               action_s2;
	logic [HELD_W-1:0]  held_s2;
	logic [LVL_W-1:0]   level_s2;
	logic               action_s3;
	logic [HELD_W-1:0]  held_s3;
	logic [WIDTH_W-1:0] width_s3;

	// Each stage moves on when the next one is empty or moving on itself.
	always_comb begin
		ctl.adv3 = valid_s3 && (!out_valid_q || result.ready);
		ctl.adv2 = valid_s2 && (!valid_s3 || ctl.adv3);
		ctl.adv1 = valid_s1 && (!valid_s2 || ctl.adv2);
		ctl.take = item.valid && item.ready;
	end

	assign item.ready = !valid_s1 || ctl.adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1    <= ctl.take || (valid_s1 && !ctl.adv1);
			valid_s2    <= ctl.adv1 || (valid_s2 && !ctl.adv2);
			valid_s3    <= ctl.adv2 || (valid_s3 && !ctl.adv3);
			out_valid_q <= ctl.adv3 || (out_valid_q && !result.ready);
		end
	end

	spa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spa_level #(.ADC_BITS(ADC_BITS)) u_level (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctl        (ctl),
		.action     (item.action),
		.adc_sample (item.adc_sample),
		.action_s2  (action_s2),
		.held_s2    (held_s2),
		.level_s2   (level_s2)
	);

	spa_scale #(.ADC_BITS(ADC_BITS)) u_scale (
		.clk       (clk),
		.cfg       (cfg),
		.ctl       (ctl),
		.action_s2 (action_s2),
		.held_s2   (held_s2),
		.level_s2  (level_s2),
		.action_s3 (action_s3),
		.held_s3   (held_s3),
		.width_s3  (width_s3)
	);

	spa_pwm u_pwm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.ctl       (ctl),
		.action_s3 (action_s3),
		.held_s3   (held_s3),
		.width_s3  (width_s3),
		.pin_out   (result.servo_pin),
		.width_out (result.pulse_width),
		.held_out  (result.held_level)
	);

	assign result.valid = out_valid_q;

	empty_input_stage_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("input stage empty but not ready");

	full_pipe_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && out_valid_q && !result.ready) |-> !item.ready)
		else $error("item taken while every stage is full and the output is stalled");

endmodule

[sv/spa_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_cfg_regs: configuration register file
// Write-only registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module spa_cfg_regs
	import spa_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period_ticks    <= PERIOD_TICKS_RST;
			cfg_q.min_pulse       <= MIN_PULSE_RST;
			cfg_q.pulse_span      <= PULSE_SPAN_RST;
			cfg_q.hysteresis_step <= HYSTERESIS_STEP_RST;
			cfg_q.low_cut         <= LOW_CUT_RST;
			cfg_q.high_cut        <= HIGH_CUT_RST;
			cfg_q.dead_low        <= DEAD_LOW_RST;
			cfg_q.dead_high       <= DEAD_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PERIOD_TICKS:    cfg_q.period_ticks    <= cfg_data[PERIOD_W-1:0];
				REG_MIN_PULSE:       cfg_q.min_pulse       <= cfg_data[PULSE_W-1:0];
				REG_PULSE_SPAN:      cfg_q.pulse_span      <= cfg_data[PULSE_W-1:0];
				REG_HYSTERESIS_STEP: cfg_q.hysteresis_step <= cfg_data[CUT_W-1:0];
				REG_LOW_CUT:         cfg_q.low_cut         <= cfg_data[CUT_W-1:0];
				REG_HIGH_CUT:        cfg_q.high_cut        <= cfg_data[CUT_W-1:0];
				REG_DEAD_LOW:        cfg_q.dead_low        <= cfg_data[CUT_W-1:0];
				REG_DEAD_HIGH:       cfg_q.dead_high       <= cfg_data[CUT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[sv/spa_level.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_level: input register, smoothing filter, hysteresis and level mapping
// Owns the smoothed and held state; hands the mapped level to stage 2.
// ----------------------------------------------------------------------------
module spa_level
	import spa_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF,
	localparam int LVL_W = (ADC_BITS > HELD_W) ? ADC_BITS : HELD_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  pipe_ctl_t           ctl,
	input  logic                action,
	input  logic [SAMPLE_W-1:0] adc_sample,
	output logic                action_s2,
	output logic [HELD_W-1:0]   held_s2,
	output logic [LVL_W-1:0]    level_s2
);

	localparam logic [LVL_W-1:0] ADC_MAX = LVL_W'((1 << ADC_BITS) - 1);

	logic                action_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic [HELD_W-1:0]   smoothed_q;
	logic [HELD_W-1:0]   held_q;

	logic [LVL_W-1:0]    x_ext;
	logic [HELD_W-1:0]   x_sat;
	logic [HELD_W+1:0]   filt_sum;
	logic [HELD_W-1:0]   smooth_nxt;
	logic [HELD_W-1:0]   diff;
	logic [HELD_W-1:0]   held_nxt;
	logic [LVL_W-1:0]    level;
	logic                upd;

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			action_s1 <= action;
			sample_s1 <= adc_sample;
		end
	end

	assign upd = ctl.adv1 && (action_s1 == ACT_SAMPLE);

	always_comb begin
		// Narrow converters saturate the sample at their full scale.
		x_ext = LVL_W'(sample_s1);
		x_sat = (x_ext > ADC_MAX) ? ADC_MAX[HELD_W-1:0] : sample_s1;

		filt_sum   = {2'b00, smoothed_q} + {1'b0, smoothed_q, 1'b0} + {2'b00, x_sat};
		smooth_nxt = filt_sum[HELD_W+1:2];

		diff = (smooth_nxt > held_q) ? (smooth_nxt - held_q) : (held_q - smooth_nxt);
		if (action_s1 == ACT_SAMPLE && diff > cfg.hysteresis_step) begin
			held_nxt = smooth_nxt;
		end else begin
			held_nxt = held_q;
		end

		// The cuts are applied in order; the dead band test sees the clamped value.
		level = LVL_W'(held_nxt);
		if (level > LVL_W'(cfg.high_cut)) begin
			level = ADC_MAX;
		end
		if (level < LVL_W'(cfg.low_cut)) begin
			level = '0;
		end
		if (level < LVL_W'(cfg.dead_high) && level > LVL_W'(cfg.dead_low)) begin
			level = LVL_W'(CENTRE_LEVEL);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q <= CENTRE_LEVEL;
			held_q     <= CENTRE_LEVEL;
		end else if (upd) begin
			smoothed_q <= smooth_nxt;
			held_q     <= held_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv1) begin
			action_s2 <= action_s1;
			held_s2   <= held_nxt;
			level_s2  <= level;
		end
	end

	held_only_on_sample: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(held_q))
		else $error("held level changed without a sample transfer");

endmodule

[sv/spa_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_scale: level to pulse width scaling
// Stage 2 multiplies by the span; stage 3 divides by full scale and adds
// the minimum pulse with saturation.
// ----------------------------------------------------------------------------
module spa_scale
	import spa_pkg::*;
#(
	parameter int ADC_BITS = ADC_BITS_DEF,
	localparam int LVL_W = (ADC_BITS > HELD_W) ? ADC_BITS : HELD_W
) (
	input  logic               clk,
	input  cfg_t               cfg,
	input  pipe_ctl_t          ctl,
	input  logic               action_s2,
	input  logic [HELD_W-1:0]  held_s2,
	input  logic [LVL_W-1:0]   level_s2,
	output logic               action_s3,
	output logic [HELD_W-1:0]  held_s3,
	output logic [WIDTH_W-1:0] width_s3
);

	localparam int PROD_W = LVL_W + PULSE_W;
	localparam int FOLDS  = (PROD_W + ADC_BITS - 1) / ADC_BITS + 1;
	localparam logic [PROD_W-1:0] FULL_SCALE = PROD_W'((1 << ADC_BITS) - 1);

	logic [PROD_W-1:0] prod_s3;
	logic [PROD_W-1:0] rem;
	logic [PROD_W-1:0] hi;
	logic [PROD_W-1:0] quot;
	logic [PROD_W:0]   wsum;

	always_ff @(posedge clk) begin
		if (ctl.adv2) begin
			action_s3 <= action_s2;
			held_s3   <= held_s2;
			prod_s3   <= PROD_W'(level_s2) * PROD_W'(cfg.pulse_span);
		end
	end

	// Division by 2^N - 1: each fold moves the bits above N into the quotient
	// and adds them back into the remainder, since 2^N leaves a remainder of 1.
	// Once the remainder is below twice the divisor, one compare finishes it.
	always_comb begin
		rem  = prod_s3;
		quot = '0;
		for (int i = 0; i < FOLDS; i++) begin
			hi   = rem >> ADC_BITS;
			quot = quot + hi;
			rem  = hi + (rem & FULL_SCALE);
		end
		quot = quot + PROD_W'(rem >= FULL_SCALE);

		wsum = (PROD_W + 1)'(cfg.min_pulse) + (PROD_W + 1)'(quot);
		if (|wsum[PROD_W:WIDTH_W]) begin
			width_s3 = '1;
		end else begin
			width_s3 = wsum[WIDTH_W-1:0];
		end
	end

endmodule

[sv/spa_pwm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pwm: period counter, pin control and result register
// Samples update the pending width; ticks advance the period and drive the pin.
// ----------------------------------------------------------------------------
module spa_pwm
	import spa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  pipe_ctl_t          ctl,
	input  logic               action_s3,
	input  logic [HELD_W-1:0]  held_s3,
	input  logic [WIDTH_W-1:0] width_s3,
	output logic               pin_out,
	output logic [WIDTH_W-1:0] width_out,
	output logic [HELD_W-1:0]  held_out
);

	logic [WIDTH_W-1:0]  pending_q;
	logic [WIDTH_W-1:0]  active_q;
	logic [PERIOD_W-1:0] count_q;
	logic                pin_q;

	logic [WIDTH_W-1:0]  pending_nxt;
	logic [WIDTH_W-1:0]  active_nxt;
	logic [PERIOD_W-1:0] count_inc;
	logic [PERIOD_W-1:0] count_nxt;
	logic                pin_nxt;

	logic                out_pin_q;
	logic [WIDTH_W-1:0]  out_width_q;
	logic [HELD_W-1:0]   out_held_q;

	always_comb begin
		pending_nxt = pending_q;
		active_nxt  = active_q;
		count_nxt   = count_q;
		pin_nxt     = pin_q;
		count_inc   = count_q + PERIOD_W'(1);
		if (action_s3 == ACT_SAMPLE) begin
			pending_nxt = width_s3;
		end else begin
			if (count_inc >= cfg.period_ticks) begin
				count_nxt  = '0;
				pin_nxt    = 1'b1;
				active_nxt = pending_q;
			end else begin
				count_nxt = count_inc;
			end
			// A zero width drops the pin again in the same tick as the wrap.
			if (count_nxt == active_nxt) begin
				pin_nxt = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= WIDTH_RST;
			active_q  <= WIDTH_RST;
			count_q   <= '0;
			pin_q     <= 1'b0;
		end else if (ctl.adv3) begin
			pending_q <= pending_nxt;
			active_q  <= active_nxt;
			count_q   <= count_nxt;
			pin_q     <= pin_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv3) begin
			out_pin_q   <= pin_nxt;
			out_width_q <= pending_nxt;
			out_held_q  <= held_s3;
		end
	end

	assign pin_out   = out_pin_q;
	assign width_out = out_width_q;
	assign held_out  = out_held_q;

	// While the pin is high the counter has not yet reached the active width.
	pin_high_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		pin_q |-> (count_q < active_q))
		else $error("pin high with counter at or past the active width");

endmodule
